// File: rtl/ajfs_pkg.sv
`timescale 1ns / 1ps

package ajfs_pkg;

    // Widths of the character stream
    localparam int CP_W    = 21;
    localparam int BASE_W  = 11;
    localparam int FORM_W  = 16;

    // Table size and the block of code points it can match
    localparam int TABLE_SIZE = 40;
    localparam logic [CP_W-1:0] RTL_LOW  = 21'h000590;
    localparam logic [CP_W-1:0] RTL_HIGH = 21'h00085F;

    // Result buffer depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // A form of zero means the letter has no such form
    localparam logic [FORM_W-1:0] NO_FORM = 16'h0000;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [FORM_W-1:0] iso;
        logic [FORM_W-1:0] fin;
        logic [FORM_W-1:0] ini;
        logic [FORM_W-1:0] med;
    } shape_row_t;

    typedef struct packed {
        logic              hit;
        logic [FORM_W-1:0] iso;
        logic [FORM_W-1:0] fin;
        logic [FORM_W-1:0] ini;
        logic [FORM_W-1:0] med;
    } shape_hit_t;

    typedef struct packed {
        logic [CP_W-1:0] shaped_code_point;
        logic            is_last;
    } out_item_t;

    // Letters U+0622..U+063A and U+0641..U+064A, harakat U+064E..U+0652, with their forms
    localparam shape_row_t SHAPE_TABLE [TABLE_SIZE] = '{
        '{11'h622, 16'hFE81, 16'hFE82, 16'h0000, 16'h0000},
        '{11'h623, 16'hFE83, 16'hFE84, 16'h0000, 16'h0000},
        '{11'h624, 16'hFE85, 16'hFE86, 16'h0000, 16'h0000},
        '{11'h625, 16'hFE87, 16'hFE88, 16'h0000, 16'h0000},
        '{11'h626, 16'hFE89, 16'hFE8A, 16'hFE8B, 16'hFE8C},
        '{11'h627, 16'hFE8D, 16'hFE8E, 16'h0000, 16'h0000},
        '{11'h628, 16'hFE8F, 16'hFE90, 16'hFE91, 16'hFE92},
        '{11'h629, 16'hFE93, 16'hFE94, 16'h0000, 16'h0000},
        '{11'h62A, 16'hFE95, 16'hFE96, 16'hFE97, 16'hFE98},
        '{11'h62B, 16'hFE99, 16'hFE9A, 16'hFE9B, 16'hFE9C},
        '{11'h62C, 16'hFE9D, 16'hFE9E, 16'hFE9F, 16'hFEA0},
        '{11'h62D, 16'hFEA1, 16'hFEA2, 16'hFEA3, 16'hFEA4},
        '{11'h62E, 16'hFEA5, 16'hFEA6, 16'hFEA7, 16'hFEA8},
        '{11'h62F, 16'hFEA9, 16'hFEAA, 16'h0000, 16'h0000},
        '{11'h630, 16'hFEAB, 16'hFEAC, 16'h0000, 16'h0000},
        '{11'h631, 16'hFEAD, 16'hFEAE, 16'h0000, 16'h0000},
        '{11'h632, 16'hFEAF, 16'hFEB0, 16'h0000, 16'h0000},
        '{11'h633, 16'hFEB1, 16'hFEB2, 16'hFEB3, 16'hFEB4},
        '{11'h634, 16'hFEB5, 16'hFEB6, 16'hFEB7, 16'hFEB8},
        '{11'h635, 16'hFEB9, 16'hFEBA, 16'hFEBB, 16'hFEBC},
        '{11'h636, 16'hFEBD, 16'hFEBE, 16'hFEBF, 16'hFEC0},
        '{11'h637, 16'hFEC1, 16'hFEC2, 16'hFEC3, 16'hFEC4},
        '{11'h638, 16'hFEC5, 16'hFEC6, 16'hFEC7, 16'hFEC8},
        '{11'h639, 16'hFEC9, 16'hFECA, 16'hFECB, 16'hFECC},
        '{11'h63A, 16'hFECD, 16'hFECE, 16'hFECF, 16'hFED0},
        '{11'h641, 16'hFED1, 16'hFED2, 16'hFED3, 16'hFED4},
        '{11'h642, 16'hFED5, 16'hFED6, 16'hFED7, 16'hFED8},
        '{11'h643, 16'hFED9, 16'hFEDA, 16'hFEDB, 16'hFEDC},
        '{11'h644, 16'hFEDD, 16'hFEDE, 16'hFEDF, 16'hFEE0},
        '{11'h645, 16'hFEE1, 16'hFEE2, 16'hFEE3, 16'hFEE4},
        '{11'h646, 16'hFEE5, 16'hFEE6, 16'hFEE7, 16'hFEE8},
        '{11'h647, 16'hFEE9, 16'hFEEA, 16'hFEEB, 16'hFEEC},
        '{11'h648, 16'hFEED, 16'hFEEE, 16'h0000, 16'h0000},
        '{11'h649, 16'hFEEF, 16'hFEF0, 16'h0000, 16'h0000},
        '{11'h64A, 16'hFEF1, 16'hFEF2, 16'hFEF3, 16'hFEF4},
        '{11'h64E, 16'hFE76, 16'h0000, 16'h0000, 16'hFE77},
        '{11'h64F, 16'hFE78, 16'h0000, 16'h0000, 16'hFE79},
        '{11'h650, 16'hFE7A, 16'h0000, 16'h0000, 16'hFE7B},
        '{11'h651, 16'hFE7C, 16'h0000, 16'h0000, 16'hFE7D},
        '{11'h652, 16'hFE7E, 16'h0000, 16'h0000, 16'hFE7F}
    };

    // Match a code point against every table row in parallel
    function automatic shape_hit_t find_row(input logic [CP_W-1:0] cp);
        shape_hit_t r;
        r = '0;
        if (cp >= RTL_LOW && cp <= RTL_HIGH)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                if (cp == {{(CP_W-BASE_W){1'b0}}, SHAPE_TABLE[i].base})
                begin
                    r.hit = 1'b1;
                    r.iso = SHAPE_TABLE[i].iso;
                    r.fin = SHAPE_TABLE[i].fin;
                    r.ini = SHAPE_TABLE[i].ini;
                    r.med = SHAPE_TABLE[i].med;
                end
            end
        end
        return r;
    endfunction

    // Joins toward its right-hand display neighbour
    function automatic logic joins_rightward(input shape_hit_t r);
        return r.hit && (r.fin != NO_FORM || r.med != NO_FORM);
    endfunction

    // Joins toward its left-hand display neighbour
    function automatic logic joins_leftward(input shape_hit_t r);
        return r.hit && (r.ini != NO_FORM || r.med != NO_FORM);
    endfunction

    // Pick the contextual form; unknown characters pass through
    function automatic logic [CP_W-1:0] shape_one(input logic [CP_W-1:0] cp,
                                                  input shape_hit_t r,
                                                  input logic left,
                                                  input logic right);
        logic [FORM_W-1:0] f;
        if (!left)
            f = (right && r.fin != NO_FORM) ? r.fin : r.iso;
        else if (right)
            f = (r.med != NO_FORM) ? r.med : r.fin;
        else
            f = (r.ini != NO_FORM) ? r.ini : r.iso;
        return r.hit ? {{(CP_W-FORM_W){1'b0}}, f} : cp;
    endfunction

endpackage

// File: rtl/ajfs_if.sv
`timescale 1ns / 1ps

// Input character channel
interface ajfs_in_if;
    logic                     valid;
    logic                     ready;
    logic [ajfs_pkg::CP_W-1:0] code_point;
    logic                     end_of_string;

    modport source (output valid, output code_point, output end_of_string, input ready);
    modport sink   (input valid, input code_point, input end_of_string, output ready);
endinterface

// Shaped character channel
interface ajfs_out_if;
    logic                     valid;
    logic                     ready;
    logic [ajfs_pkg::CP_W-1:0] shaped_code_point;
    logic                     is_last;

    modport source (output valid, output shaped_code_point, output is_last, input ready);
    modport sink   (input valid, input shaped_code_point, input is_last, output ready);
endinterface

// File: rtl/arabic_joining_form_shaper_core.sv
`timescale 1ns / 1ps

// Streaming Arabic contextual shaper. It takes one display-order code point per
// cycle while its queue has room and returns each character in its isolated,
// final, initial or medial presentation form, chosen from a 40-entry constant
// table on the unshaped neighbours; characters outside the table pass through
// unchanged. Each character is held until its right neighbour arrives, so a
// result appears one input behind, and an end-of-string character flushes both
// the held character and itself in the same transfer. Sustained rate is one
// character per cycle: the table match and form selection are combinational
// between the held character and a four-entry result queue, and the input takes
// a transfer whenever the queue has two free slots, which with the output always
// ready is every cycle. Each result is written into the queue at its transfer.
module arabic_joining_form_shaper_core (
    input  logic           clk,
    input  logic           rst_n,
    ajfs_in_if.sink        chars,
    ajfs_out_if.source     glyphs
);

    // Held character and its left-join flag
    logic [ajfs_pkg::CP_W-1:0] pending_char_reg, pending_char_next;
    logic                      pending_valid_reg, pending_valid_next;
    logic                      left_joins_reg, left_joins_next;

    // Result queue
    ajfs_pkg::out_item_t       queue_reg [ajfs_pkg::QDEPTH];
    logic [ajfs_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ajfs_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ajfs_pkg::QCNT_W-1:0] count_reg, count_next;

    logic                      in_xfer;
    logic                      out_xfer;
    ajfs_pkg::shape_hit_t      new_row;
    ajfs_pkg::shape_hit_t      held_row;
    logic                      new_left;
    ajfs_pkg::out_item_t       item_a;
    ajfs_pkg::out_item_t       item_b;
    logic                      push_a;
    logic                      push_b;
    logic [ajfs_pkg::QCNT_W-1:0] push_cnt;
    logic [ajfs_pkg::QPTR_W-1:0] wr_ptr_b;

    // Accept while two slots are free
    assign chars.ready = (count_reg <= ajfs_pkg::QCNT_W'(ajfs_pkg::QDEPTH - 2));
    assign in_xfer     = chars.valid && chars.ready;

    assign glyphs.valid             = (count_reg != '0);
    assign glyphs.shaped_code_point = queue_reg[rd_ptr_reg].shaped_code_point;
    assign glyphs.is_last           = queue_reg[rd_ptr_reg].is_last;
    assign out_xfer                 = glyphs.valid && glyphs.ready;

    // Shape the held character against the new one, and the new one if last
    always_comb
    begin
        new_row  = ajfs_pkg::find_row(chars.code_point);
        held_row = ajfs_pkg::find_row(pending_char_reg);
        new_left = pending_valid_reg && ajfs_pkg::joins_rightward(held_row);

        item_b.shaped_code_point = ajfs_pkg::shape_one(chars.code_point, new_row,
                                                       new_left, 1'b0);
        item_b.is_last           = 1'b1;

        if (pending_valid_reg)
        begin
            item_a.shaped_code_point = ajfs_pkg::shape_one(pending_char_reg, held_row,
                                           left_joins_reg,
                                           ajfs_pkg::joins_leftward(new_row));
            item_a.is_last           = 1'b0;
        end
        else
        begin
            item_a = item_b;
        end

        push_a   = in_xfer && (pending_valid_reg || chars.end_of_string);
        push_b   = in_xfer && pending_valid_reg && chars.end_of_string;
        push_cnt = ajfs_pkg::QCNT_W'({1'b0, push_a}) + ajfs_pkg::QCNT_W'({1'b0, push_b});
        wr_ptr_b = wr_ptr_reg + ajfs_pkg::QPTR_W'(1);
    end

    // Advance the held character and the queue pointers
    always_comb
    begin
        pending_char_next  = pending_char_reg;
        pending_valid_next = pending_valid_reg;
        left_joins_next    = left_joins_reg;
        if (in_xfer)
        begin
            if (chars.end_of_string)
            begin
                pending_char_next  = '0;
                pending_valid_next = 1'b0;
                left_joins_next    = 1'b0;
            end
            else
            begin
                pending_char_next  = chars.code_point;
                pending_valid_next = 1'b1;
                left_joins_next    = new_left;
            end
        end

        wr_ptr_next = wr_ptr_reg + ajfs_pkg::QPTR_W'(push_cnt);
        rd_ptr_next = out_xfer ? rd_ptr_reg + ajfs_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - ajfs_pkg::QCNT_W'({1'b0, out_xfer});
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_char_reg  <= '0;
            pending_valid_reg <= 1'b0;
            left_joins_reg    <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            pending_char_reg  <= pending_char_next;
            pending_valid_reg <= pending_valid_next;
            left_joins_reg    <= left_joins_next;
            wr_ptr_reg        <= wr_ptr_next;
            rd_ptr_reg        <= rd_ptr_next;
            count_reg         <= count_next;
        end
    end

    // Write results into the queue
    always_ff @(posedge clk)
    begin
        if (push_a)
            queue_reg[wr_ptr_reg] <= item_a;
        if (push_b)
            queue_reg[wr_ptr_b] <= item_b;
    end

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ajfs_pkg::QCNT_W'(ajfs_pkg::QDEPTH))
        else $error("result queue overflow");

    // A transfer only happens with room for two results
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> count_reg <= ajfs_pkg::QCNT_W'(ajfs_pkg::QDEPTH - 2))
        else $error("input taken without room for two results");

    // End of string flushes the held character
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && chars.end_of_string) |=> !pending_valid_reg && !left_joins_reg)
        else $error("window not flushed after end of string");

    // A mid-line character is held afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !chars.end_of_string) |=> pending_valid_reg)
        else $error("character not held");

    // Left-join flag only with a held character
    assert property (@(posedge clk) disable iff (!rst_n)
        left_joins_reg |-> pending_valid_reg)
        else $error("left-join flag without held character");

endmodule

// File: dv/tb_arabic_joining_form_shaper_core.sv
`timescale 1ns / 1ps

module tb_arabic_joining_form_shaper_core;

    localparam int CP_W = ajfs_pkg::CP_W;

    localparam int ITEM_TARGET  = 1450;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [15:0] ABSENT_FORM = 16'h0000;

    typedef struct packed {
        logic        hit;
        logic [15:0] iso;
        logic [15:0] fin;
        logic [15:0] ini;
        logic [15:0] med;
    } glyph_forms_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } glyph_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ajfs_in_if  chars();
    ajfs_out_if glyphs();

    arabic_joining_form_shaper_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .glyphs (glyphs)
    );

    // Shaping context mirrored from the stream
    logic [CP_W-1:0] held_cp = '0;
    logic            held_valid = 1'b0;
    logic            held_left_joins = 1'b0;

    glyph_t expected_glyphs[$];
    int     mismatch_count = 0;
    int     items_sent = 0;
    int     burst_left = 0;
    int     cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Presentation forms of the letters and harakat, packed iso/fin/ini/med
    function automatic glyph_forms_t forms_of(input logic [CP_W-1:0] cp);
        glyph_forms_t f;
        logic [63:0]  row;
        row = '0;
        f = '0;
        f.hit = 1'b1;
        case (cp)
            21'h622: row = 64'hFE81_FE82_0000_0000;
            21'h623: row = 64'hFE83_FE84_0000_0000;
            21'h624: row = 64'hFE85_FE86_0000_0000;
            21'h625: row = 64'hFE87_FE88_0000_0000;
            21'h626: row = 64'hFE89_FE8A_FE8B_FE8C;
            21'h627: row = 64'hFE8D_FE8E_0000_0000;
            21'h628: row = 64'hFE8F_FE90_FE91_FE92;
            21'h629: row = 64'hFE93_FE94_0000_0000;
            21'h62A: row = 64'hFE95_FE96_FE97_FE98;
            21'h62B: row = 64'hFE99_FE9A_FE9B_FE9C;
            21'h62C: row = 64'hFE9D_FE9E_FE9F_FEA0;
            21'h62D: row = 64'hFEA1_FEA2_FEA3_FEA4;
            21'h62E: row = 64'hFEA5_FEA6_FEA7_FEA8;
            21'h62F: row = 64'hFEA9_FEAA_0000_0000;
            21'h630: row = 64'hFEAB_FEAC_0000_0000;
            21'h631: row = 64'hFEAD_FEAE_0000_0000;
            21'h632: row = 64'hFEAF_FEB0_0000_0000;
            21'h633: row = 64'hFEB1_FEB2_FEB3_FEB4;
            21'h634: row = 64'hFEB5_FEB6_FEB7_FEB8;
            21'h635: row = 64'hFEB9_FEBA_FEBB_FEBC;
            21'h636: row = 64'hFEBD_FEBE_FEBF_FEC0;
            21'h637: row = 64'hFEC1_FEC2_FEC3_FEC4;
            21'h638: row = 64'hFEC5_FEC6_FEC7_FEC8;
            21'h639: row = 64'hFEC9_FECA_FECB_FECC;
            21'h63A: row = 64'hFECD_FECE_FECF_FED0;
            21'h641: row = 64'hFED1_FED2_FED3_FED4;
            21'h642: row = 64'hFED5_FED6_FED7_FED8;
            21'h643: row = 64'hFED9_FEDA_FEDB_FEDC;
            21'h644: row = 64'hFEDD_FEDE_FEDF_FEE0;
            21'h645: row = 64'hFEE1_FEE2_FEE3_FEE4;
            21'h646: row = 64'hFEE5_FEE6_FEE7_FEE8;
            21'h647: row = 64'hFEE9_FEEA_FEEB_FEEC;
            21'h648: row = 64'hFEED_FEEE_0000_0000;
            21'h649: row = 64'hFEEF_FEF0_0000_0000;
            21'h64A: row = 64'hFEF1_FEF2_FEF3_FEF4;
            21'h64E: row = 64'hFE76_0000_0000_FE77;
            21'h64F: row = 64'hFE78_0000_0000_FE79;
            21'h650: row = 64'hFE7A_0000_0000_FE7B;
            21'h651: row = 64'hFE7C_0000_0000_FE7D;
            21'h652: row = 64'hFE7E_0000_0000_FE7F;
            default: f.hit = 1'b0;
        endcase
        {f.iso, f.fin, f.ini, f.med} = row;
        return f;
    endfunction

    // A character with a final or medial form links to the one after it
    function automatic logic links_to_next(input logic [CP_W-1:0] cp);
        glyph_forms_t f;
        f = forms_of(cp);
        return f.hit && (f.fin != ABSENT_FORM || f.med != ABSENT_FORM);
    endfunction

    // A character with an initial or medial form links back to the one before it
    function automatic logic links_to_prev(input logic [CP_W-1:0] cp);
        glyph_forms_t f;
        f = forms_of(cp);
        return f.hit && (f.ini != ABSENT_FORM || f.med != ABSENT_FORM);
    endfunction

    // Choose the form from the joining state of both neighbours
    function automatic logic [CP_W-1:0] contextual_form(input logic [CP_W-1:0] cp,
                                                        input logic left,
                                                        input logic right);
        glyph_forms_t f;
        logic [15:0]  g;
        f = forms_of(cp);
        if (!left)
            g = (right && f.fin != ABSENT_FORM) ? f.fin : f.iso;
        else if (right)
            g = (f.med != ABSENT_FORM) ? f.med : f.fin;
        else
            g = (f.ini != ABSENT_FORM) ? f.ini : f.iso;
        return f.hit ? {{(CP_W-16){1'b0}}, g} : cp;
    endfunction

    // Advance the shaping window by one accepted character
    function automatic void predict_shaping(input logic [CP_W-1:0] cp, input logic eos);
        glyph_t g;
        logic   next_left;
        next_left = 1'b0;
        if (held_valid)
        begin
            g.cp = contextual_form(held_cp, held_left_joins, links_to_prev(cp));
            g.last = 1'b0;
            expected_glyphs = {expected_glyphs, g};
            next_left = links_to_next(held_cp);
        end
        if (eos)
        begin
            g.cp = contextual_form(cp, next_left, 1'b0);
            g.last = 1'b1;
            expected_glyphs = {expected_glyphs, g};
            held_cp = '0;
            held_valid = 1'b0;
            held_left_joins = 1'b0;
        end
        else
        begin
            held_cp = cp;
            held_valid = 1'b1;
            held_left_joins = next_left;
        end
    endfunction

    // Mostly table letters and harakat, with other Arabic-block and arbitrary code points
    function automatic logic [CP_W-1:0] pick_code_point();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        idx = $urandom_range(0, 39);
        if (sel < 72)
        begin
            if (idx < 25)
                return CP_W'(32'h622 + idx);
            else if (idx < 35)
                return CP_W'(32'h641 + idx - 25);
            else
                return CP_W'(32'h64E + idx - 35);
        end
        else if (sel < 82)
            return CP_W'($urandom_range(32'h590, 32'h85F));
        else if (sel < 88)
            return CP_W'($urandom_range(32'h600, 32'h6FF));
        return CP_W'($urandom_range(0, 32'h10FFFF));
    endfunction

    // Send one character; valid stays high across a burst, drops for a gap
    task automatic send_char(input logic [CP_W-1:0] cp, input logic eos);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100)
                                                     : $urandom_range(1, 10);
        end
        chars.valid <= 1'b1;
        chars.code_point <= cp;
        chars.end_of_string <= eos;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        predict_shaping(cp, eos);
        items_sent++;
        burst_left--;
        if (burst_left == 0)
            chars.valid <= 1'b0;
    endtask

    // Lines of one character: a letter, the code point extremes, a haraka
    task automatic test_single_char_lines();
        send_char(21'h000628, 1'b1);
        send_char(21'h000000, 1'b1);
        send_char(21'h10FFFF, 1'b1);
        send_char(21'h00064E, 1'b1);
    endtask

    // Initial/medial/final chains, a two-form letter breaking the chain,
    // harakat joining both ways, and a foreign character between harakat
    task automatic test_joining_forms();
        send_char(21'h000628, 1'b0);
        send_char(21'h000628, 1'b0);
        send_char(21'h000628, 1'b1);
        send_char(21'h000628, 1'b0);
        send_char(21'h000627, 1'b0);
        send_char(21'h000628, 1'b1);
        send_char(21'h000628, 1'b0);
        send_char(21'h000651, 1'b0);
        send_char(21'h000041, 1'b0);
        send_char(21'h000652, 1'b1);
    endtask

    // Edges of the Arabic block and of the gaps in the table
    task automatic test_table_edges();
        send_char(21'h000590, 1'b0);
        send_char(21'h000621, 1'b0);
        send_char(21'h000622, 1'b0);
        send_char(21'h00063A, 1'b0);
        send_char(21'h00063B, 1'b0);
        send_char(21'h000641, 1'b0);
        send_char(21'h00064A, 1'b0);
        send_char(21'h00064D, 1'b0);
        send_char(21'h000652, 1'b0);
        send_char(21'h000653, 1'b0);
        send_char(21'h00085F, 1'b1);
    endtask

    // Whole lines of random length, mostly short with some long ones
    task automatic test_random_lines();
        int line_len;
        while (items_sent < ITEM_TARGET)
        begin
            line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48)
                                                   : $urandom_range(1, 8);
            for (int k = 0; k < line_len; k++)
                send_char(pick_code_point(), k == line_len - 1);
        end
    endtask

    // Receiver: alternate ready runs and stalls of random length
    initial
    begin
        int   phase_left;
        logic phase_ready;
        phase_left = 0;
        phase_ready = 1'b0;
        glyphs.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                phase_ready = !phase_ready;
                if (phase_ready)
                    phase_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                else
                    phase_left = $urandom_range(1, 5);
            end
            glyphs.ready <= phase_ready;
            phase_left--;
        end
    end

    // Check each output transfer against the oldest expected glyph
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && glyphs.valid && glyphs.ready)
        begin
            if (expected_glyphs.size() == 0)
            begin
                $display("%0t: unexpected glyph: expected none, actual cp=%h last=%b",
                         $time, glyphs.shaped_code_point, glyphs.is_last);
                mismatch_count++;
            end
            else
            begin
                want = expected_glyphs.pop_front();
                if (glyphs.shaped_code_point !== want.cp)
                begin
                    $display("%0t: shaped_code_point mismatch: expected %h, actual %h",
                             $time, want.cp, glyphs.shaped_code_point);
                    mismatch_count++;
                end
                if (glyphs.is_last !== want.last)
                begin
                    $display("%0t: is_last mismatch: expected %b, actual %b",
                             $time, want.last, glyphs.is_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        chars.valid <= 1'b0;
        chars.code_point <= '0;
        chars.end_of_string <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_single_char_lines();
        test_joining_forms();
        test_table_edges();
        test_random_lines();
        if (burst_left != 0)
            chars.valid <= 1'b0;

        // Drain, then give the block time to show any stray transfer
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_glyphs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
